@@ sv/q2e_pkg.sv @@
// Shared types, constants and CORDIC angle table for the quaternion to Euler angles block.
package q2e_pkg;

	localparam int CordicStages = 16;
	localparam int NStages = (CordicStages > 32) ? 32 : CordicStages;
	localparam int OpW = 26;
	localparam int CordW = 28;
	localparam int AngW = 34;
	localparam int SqW = 52;
	localparam int RootW = 26;
	localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} req_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
		logic gimbal_lock;
	} rsp_t;

	function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
		logic signed [AngW-1:0] r;
		begin
			case (i)
				5'd0: r = 34'sd843314857;
				5'd1: r = 34'sd497837829;
				5'd2: r = 34'sd263043837;
				5'd3: r = 34'sd133525159;
				5'd4: r = 34'sd67021687;
				5'd5: r = 34'sd33543516;
				5'd6: r = 34'sd16775851;
				5'd7: r = 34'sd8388437;
				5'd8: r = 34'sd4194283;
				5'd9: r = 34'sd2097149;
				5'd31: r = '0;
				default: r = AngW'(64'sd1 << (30 - i));
			endcase
			atan_q30 = r;
		end
	endfunction

endpackage

@@ sv/q2e_cordic.sv @@
// Pipelined CORDIC vectoring atan2 with Q3.13 rounding and saturation.
module q2e_cordic (
	input  logic                                 clk,
	input  logic signed [q2e_pkg::OpW-1:0]       y_in,
	input  logic signed [q2e_pkg::OpW-1:0]       x_in,
	output logic signed [15:0]                   angle
);
	localparam int N = q2e_pkg::NStages;
	localparam int CW = q2e_pkg::CordW;
	localparam int AW = q2e_pkg::AngW;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [AW-1:0] a_s [0:N];
	logic                 z_s [0:N];
	logic signed [AW-1:0] rnd;
	logic signed [AW-18:0] sh;

	always_ff @(posedge clk) begin
		z_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			x_s[0] <= -CW'(x_in);
			y_s[0] <= -CW'(y_in);
			a_s[0] <= (y_in >= 0) ? q2e_pkg::PiQ30 : -q2e_pkg::PiQ30;
		end else begin
			x_s[0] <= CW'(x_in);
			y_s[0] <= CW'(y_in);
			a_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		always_ff @(posedge clk) begin
			z_s[i+1] <= z_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] + q2e_pkg::atan_q30(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] - q2e_pkg::atan_q30(5'(i));
			end
		end
	end

	assign rnd = a_s[N] + AW'(65536);
	assign sh = rnd[AW-1:17];

	always_ff @(posedge clk) begin
		if (z_s[N])
			angle <= '0;
		else if (sh > 32767)
			angle <= 16'sd32767;
		else if (sh < -32768)
			angle <= -16'sd32768;
		else
			angle <= sh[15:0];
	end
endmodule

@@ sv/q2e_isqrt.sv @@
// Pipelined restoring integer square root, one result bit per stage.
module q2e_isqrt (
	input  logic                           clk,
	input  logic [q2e_pkg::SqW-1:0]        n_in,
	output logic [q2e_pkg::RootW-1:0]      root
);
	localparam int SW = q2e_pkg::SqW;
	localparam int RW = q2e_pkg::RootW;

	logic [SW-1:0] rem_s [0:RW];
	logic [RW-1:0] res_s [0:RW];

	always_ff @(posedge clk) begin
		rem_s[0] <= n_in;
		res_s[0] <= '0;
	end

	for (genvar k = 0; k < RW; k++) begin : g_bit
		localparam int B = RW - 1 - k;
		logic [SW+1:0] trial;
		assign trial = ({2'b0, SW'(res_s[k])} << (B + 1)) | ((SW+2)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if ({2'b0, rem_s[k]} >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial[SW-1:0];
				res_s[k+1] <= res_s[k] | (RW'(1) << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				res_s[k+1] <= res_s[k];
			end
		end
	end

	assign root = res_s[RW];
endmodule

@@ sv/quaternion_to_euler_angles.sv @@
// Top level: quaternion to Euler angles, fully pipelined.
// Pipeline: product and matrix-term stages, 1 square stage, 27 square-root stages,
// then 18 CORDIC stages. Throughput: one request per clock; busy is
// held low, the pipeline never stalls and the receiver takes every result.
// Reset clears the valid chain and sets gimbal_threshold to 1; data registers
// are not reset.
module quaternion_to_euler_angles (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  q2e_pkg::req_t        req,
	output logic                 done,
	output q2e_pkg::rsp_t        rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam int OW = q2e_pkg::OpW;
	localparam int RW = q2e_pkg::RootW;
	localparam int SQL = RW + 1;               // isqrt latency
	localparam int CL = q2e_pkg::NStages + 2;  // cordic latency
	localparam int LAT = 3 + SQL + CL;

	logic [14:0] thr_q;

	// configuration register, single address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			thr_q <= pwdata[14:0];
		end
	end
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {17'd0, thr_q} : 32'd0;
	assign busy = 1'b0;

	// stage 1: pairwise products (Q.30)
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xz_s1, yw_s1, yz_s1, xw_s1, xy_s1, zw_s1;
	always_ff @(posedge clk) begin
		xx_s1 <= req.quat_x * req.quat_x;
		yy_s1 <= req.quat_y * req.quat_y;
		zz_s1 <= req.quat_z * req.quat_z;
		xz_s1 <= req.quat_x * req.quat_z;
		yw_s1 <= req.quat_y * req.quat_w;
		yz_s1 <= req.quat_y * req.quat_z;
		xw_s1 <= req.quat_x * req.quat_w;
		xy_s1 <= req.quat_x * req.quat_y;
		zw_s1 <= req.quat_z * req.quat_w;
	end

	// stage 2: matrix terms, floor to Q.22
	logic signed [34:0] one35;
	assign one35 = 35'sd1073741824;
	logic signed [34:0] t31, t32, t33, t12, t22, t11, t21;
	always_comb begin
		t31 = (35'(xz_s1) + 35'(yw_s1)) <<< 1;
		t32 = (35'(yz_s1) - 35'(xw_s1)) <<< 1;
		t33 = one35 - ((35'(xx_s1) + 35'(yy_s1)) <<< 1);
		t12 = (35'(xy_s1) + 35'(zw_s1)) <<< 1;
		t22 = one35 - ((35'(xx_s1) + 35'(zz_s1)) <<< 1);
		t11 = one35 - ((35'(yy_s1) + 35'(zz_s1)) <<< 1);
		t21 = (35'(xy_s1) - 35'(zw_s1)) <<< 1;
	end
	logic signed [OW-1:0] m31_s2, m32_s2, m33_s2, m12_s2, m22_s2, m11_s2, m21_s2;
	always_ff @(posedge clk) begin
		m31_s2 <= OW'(t31 >>> 8);
		m32_s2 <= OW'(t32 >>> 8);
		m33_s2 <= OW'(t33 >>> 8);
		m12_s2 <= OW'(t12 >>> 8);
		m22_s2 <= OW'(t22 >>> 8);
		m11_s2 <= OW'(t11 >>> 8);
		m21_s2 <= OW'(t21 >>> 8);
	end

	// stage 3: squares for cy
	logic [q2e_pkg::SqW-1:0] sum_s3;
	logic signed [51:0] sq33, sq31;
	assign sq33 = m33_s2 * m33_s2;
	assign sq31 = m31_s2 * m31_s2;
	always_ff @(posedge clk) begin
		sum_s3 <= q2e_pkg::SqW'(sq33) + q2e_pkg::SqW'(sq31);
	end

	// delay matrix terms alongside the square root
	logic signed [OW-1:0] d_s [0:SQL][0:5];
	always_ff @(posedge clk) begin
		d_s[0][0] <= -m32_s2;
		d_s[0][1] <= m31_s2;
		d_s[0][2] <= m33_s2;
		d_s[0][3] <= m12_s2;
		d_s[0][4] <= m22_s2;
		d_s[0][5] <= -m21_s2;
	end
	logic signed [OW-1:0] m11_d [0:SQL];
	always_ff @(posedge clk) m11_d[0] <= m11_s2;
	for (genvar k = 0; k < SQL; k++) begin : g_dly
		always_ff @(posedge clk) begin
			d_s[k+1] <= d_s[k];
			m11_d[k+1] <= m11_d[k];
		end
	end

	logic [RW-1:0] cy;
	q2e_isqrt u_sqrt (.clk(clk), .n_in(sum_s3), .root(cy));

	// cy is ready with d_s[SQL]; select formulas now
	logic lock;
	assign lock = (cy >> 7) <= RW'(thr_q);
	logic signed [OW-1:0] ya, xa, yb, xb;
	assign ya = lock ? d_s[SQL][5] : d_s[SQL][3];
	assign xa = lock ? m11_d[SQL] : d_s[SQL][4];
	assign yb = d_s[SQL][1];
	assign xb = d_s[SQL][2];

	logic lock_d [0:CL-1];
	always_ff @(posedge clk) lock_d[0] <= lock;
	for (genvar k = 0; k < CL - 1; k++) begin : g_lk
		always_ff @(posedge clk) lock_d[k+1] <= lock_d[k];
	end

	logic signed [15:0] pitch, yaw, roll;
	q2e_cordic u_pitch (.clk(clk), .y_in(d_s[SQL][0]), .x_in(OW'(cy)), .angle(pitch));
	q2e_cordic u_yaw   (.clk(clk), .y_in(yb), .x_in(xb), .angle(yaw));
	q2e_cordic u_roll  (.clk(clk), .y_in(ya), .x_in(xa), .angle(roll));

	// valid chain
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end
	assign done = vld_q[LAT-1];

	always_comb begin
		rsp.pitch_angle = pitch;
		rsp.yaw_angle = lock_d[CL-1] ? 16'sd0 : yaw;
		rsp.roll_angle = roll;
		rsp.gimbal_lock = lock_d[CL-1];
	end
endmodule

@@ test/tb_top.sv @@
// Testbench for the quaternion to Euler angles block: random and directed requests, scored against a local model.
module tb_top;

	localparam int Latency = 48;
	localparam longint CycleLimit = 400000;
	localparam logic [1:0] AddrThreshold = 2'd0;
	localparam longint PiAngle = 64'sd3373259426;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	q2e_pkg::req_t req = '0;
	logic done;
	q2e_pkg::rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	quaternion_to_euler_angles dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Requests waiting for the driver, and predictions waiting for their results.
	q2e_pkg::req_t pending_reqs[$];
	q2e_pkg::rsp_t expected_angles[$];
	int send_idle_pct = 0;
	bit hold_requests = 1'b0;
	int mismatches = 0;
	longint cycle_count = 0;
	logic [14:0] threshold_model = 15'd1;

	// Floor-shift arithmetic right, as the hardware does.
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint res, bitv;
		res = 0;
		bitv = 64'sd1 <<< 62;
		while (bitv > n) bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] vector_angle(longint y, longint x);
		longint ang, xs, ys, r;
		if (x == 0 && y == 0) return 16'sd0;
		ang = 0;
		if (x < 0) begin
			ang = (y >= 0) ? PiAngle : -PiAngle;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < q2e_pkg::NStages; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; ang += longint'(q2e_pkg::atan_q30(5'(i)));
			end else begin
				x -= ys; y += xs; ang -= longint'(q2e_pkg::atan_q30(5'(i)));
			end
		end
		r = (ang + 65536) >>> 17;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	function automatic q2e_pkg::rsp_t euler_from_quat(q2e_pkg::req_t q, logic [14:0] thr);
		longint x, y, z, w, xx, yy, zz, m31, m32, m33, cy;
		q2e_pkg::rsp_t a;
		x = longint'(q.quat_x);
		y = longint'(q.quat_y);
		z = longint'(q.quat_z);
		w = longint'(q.quat_w);
		xx = x * x; yy = y * y; zz = z * z;
		m31 = shr_floor(2 * (x * z + y * w), 8);
		m32 = shr_floor(2 * (y * z - x * w), 8);
		m33 = shr_floor((64'sd1 <<< 30) - 2 * (xx + yy), 8);
		cy = int_sqrt(m33 * m33 + m31 * m31);
		a.pitch_angle = vector_angle(-m32, cy);
		if ((cy >>> 7) > longint'(thr)) begin
			a.yaw_angle = vector_angle(m31, m33);
			a.roll_angle = vector_angle(shr_floor(2 * (x * y + z * w), 8),
				shr_floor((64'sd1 <<< 30) - 2 * (xx + zz), 8));
			a.gimbal_lock = 1'b0;
		end else begin
			a.yaw_angle = 16'sd0;
			a.roll_angle = vector_angle(-shr_floor(2 * (x * y - z * w), 8),
				shr_floor((64'sd1 <<< 30) - 2 * (yy + zz), 8));
			a.gimbal_lock = 1'b1;
		end
		return a;
	endfunction

	// Driver: present the next request, hold start while the block is busy.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_angles.push_back(euler_from_quat(req, threshold_model));
			end
			if (start && busy) begin
				// hold the current request
			end else if (!hold_requests && pending_reqs.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: score every strobed result against the oldest prediction.
	always @(posedge clk) begin
		q2e_pkg::rsp_t want;
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb_top failed");
			$finish;
		end else if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp);
			end else begin
				want = expected_angles.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: want %p got %p", want, rsp);
				end
			end
		end
	end

	task automatic write_threshold(input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrThreshold; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		threshold_model = val[14:0];
	endtask

	// Wait until the pipe is empty and no result can still be in flight.
	task automatic drain();
		while (pending_reqs.size() != 0 || start || expected_angles.size() != 0)
			@(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(int'($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random(int n);
		q2e_pkg::req_t q;
		real c, s;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
			end else if ($urandom_range(4) == 0) begin
				// near gimbal lock: pitch close to +-90 degrees
				q.quat_x = 16'sd23170 + 16'(int'($urandom_range(40)) - 20);
				q.quat_w = ($urandom_range(1) ? 16'sd23170 : -16'sd23170)
					+ 16'(int'($urandom_range(40)) - 20);
				q.quat_y = 16'(int'($urandom_range(200)) - 100);
				q.quat_z = 16'(int'($urandom_range(200)) - 100);
			end else begin
				// quaternion formed from two random values; its norm is not held at one
				c = ($urandom_range(65535) - 32768.0) / 32768.0;
				s = ($urandom_range(65535) - 32768.0) / 32768.0;
				q.quat_x = 16'($rtoi(c * 23000.0));
				q.quat_y = 16'($rtoi(s * 23000.0));
				q.quat_z = 16'($rtoi((c * s) * 16000.0));
				q.quat_w = 16'($rtoi((1.0 - c * c) * 16000.0));
			end
			pending_reqs.push_back(q);
		end
	endtask

	initial begin
		logic [15:0] edge_vals[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, zero vector, gimbal lock both ways, field extremes.
		pending_reqs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
		pending_reqs.push_back('0);
		pending_reqs.push_back('{16'sd23170, 16'sd0, 16'sd0, 16'sd23170});
		pending_reqs.push_back('{16'sd23170, 16'sd0, 16'sd0, -16'sd23170});
		pending_reqs.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0});
		pending_reqs.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
		pending_reqs.push_back('{16'sd0, 16'sd0, -16'sd32768, 16'sd0});
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back({edge_vals[i], edge_vals[(i + 1) % 4],
				edge_vals[(i + 2) % 4], edge_vals[(i + 3) % 4]});
		pending_reqs.push_back({4{16'h8000}});
		pending_reqs.push_back({4{16'h7FFF}});
		drain();

		write_threshold(32'h0000_4000);
		send_idle_pct = 24;
		queue_random(600);
		drain();

		write_threshold(32'hFFFF_7FFF);
		send_idle_pct = 65;
		queue_random(300);
		// pause the sender until every outstanding result has come back
		while (pending_reqs.size() > 150) @(posedge clk);
		hold_requests = 1'b1;
		while (start || expected_angles.size() != 0) @(posedge clk);
		hold_requests = 1'b0;
		drain();

		write_threshold(32'h0000_0000);
		send_idle_pct = 0;
		queue_random(450);
		drain();

		write_threshold(32'h0000_0200);
		queue_random(450);
		drain();

		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
